// ----- src/gbn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the Go-Back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int PAYLOAD_W = 64;
	localparam int ACKF_W    = 20;
	localparam int CSUM_W    = 32;
	localparam int SEQ_W     = 4;
	localparam int PSUM_W    = 12;
	localparam int TICK_W    = 16;
	// Sequence numbers run modulo twice the window, so the window is tied to SEQ_W.
	localparam int WINDOW_DEPTH = 8;
	localparam int BUFFER_DEPTH = 64;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20;
	localparam logic [39:0] NACK_WORD = 40'h00_4B43414E;

	typedef enum logic [1:0] {
		CMD_SEND = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [PAYLOAD_W-1:0] payload;
		logic [ACKF_W-1:0]    ack_seq;
		logic [ACKF_W-1:0]    ack_num;
		logic [CSUM_W-1:0]    ack_checksum;
	} in_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]     pkt_seq;
		logic [PSUM_W-1:0]    pkt_checksum;
		logic [PAYLOAD_W-1:0] pkt_payload;
		logic                 is_resend;
		logic                 last;
	} out_item_t;

	// Classified request passed from front to back.
	typedef enum logic [1:0] {
		OP_SEND   = 2'd0,
		OP_ACK    = 2'd1,
		OP_TICK   = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [PAYLOAD_W-1:0] payload;
		logic [ACKF_W-1:0]    ack_num;
	} req_t;

	// Sum of signed bytes, only the low nbytes bytes count.
	function automatic logic signed [11:0] byte_sum(input logic [63:0] p, input int nbytes);
		logic signed [11:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < nbytes)
				s = s + 12'(signed'(p[8*i +: 8]));
		end
		return s;
	endfunction

endpackage

// ----- src/gbn_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface gbn_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/gbn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_front
// Accepts input requests, checks ack checksum and NACK, pushes a request queue.
// ----------------------------------------------------------------------------
module gbn_front #(
	parameter int PAYLOAD_BYTES = 8,
	parameter int QDEPTH        = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gbn_pkg::in_item_t  in_data,
	output logic               q_valid,
	input  logic               q_ready,
	output gbn_pkg::req_t      q_data
);
	import gbn_pkg::*;

	localparam int QW = $clog2(QDEPTH);
	localparam logic [63:0] PMASK = ~64'd0 >> (64 - 8 * PAYLOAD_BYTES);

	req_t               q_mem_q [QDEPTH];
	logic [QW-1:0]      wr_q, rd_q;
	logic [QW:0]        cnt_q;
	logic [63:0]        pay;
	logic signed [33:0] calc, carried;
	logic               good;
	req_t               req;
	logic               push, pop;

	always_comb begin
		pay     = in_data.payload & PMASK;
		calc    = 34'(in_data.ack_seq) + 34'(in_data.ack_num)
			+ 34'(byte_sum(pay, PAYLOAD_BYTES));
		carried = 34'(signed'(in_data.ack_checksum));
		good    = (calc == carried) && (pay[39:0] != NACK_WORD);
		req.payload = pay;
		req.ack_num = in_data.ack_num;
		case (in_data.cmd)
			CMD_SEND: req.op = OP_SEND;
			CMD_ACK:  req.op = good ? OP_ACK : OP_IGNORE;
			CMD_TICK: req.op = OP_TICK;
			default:  req.op = OP_IGNORE;
		endcase
	end

	assign in_ready = (cnt_q != (QW+1)'(QDEPTH));
	assign push     = in_valid && in_ready && (req.op != OP_IGNORE);
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_data   = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QW+1)'(QDEPTH)) else $error("queue overfill");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> !push) else $error("push while full");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
endmodule

// ----- src/gbn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_back
// Executes requests: send buffer, window, timer; takes a new request only when idle.
// ----------------------------------------------------------------------------
module gbn_back #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [gbn_pkg::TICK_W-1:0]   timeout_ticks,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  gbn_pkg::req_t                q_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output gbn_pkg::out_item_t           out_data
);
	import gbn_pkg::*;

	localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int BW = $clog2(BUFFER_DEPTH);
	localparam int SEQ_MOD = 2 * WINDOW_DEPTH;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_SEND = 4'b0100,
		ST_RSND = 4'b1000
	} state_t;

	state_t state_q;

	logic [63:0]       buf_mem [BUFFER_DEPTH];
	logic [63:0]       buf_rd_q;
	logic [BW-1:0]     bhead_q;
	logic [BW:0]       bcnt_q;

	logic [SEQ_W-1:0]  wseq_q [WINDOW_DEPTH];
	logic [PSUM_W-1:0] wsum_q [WINDOW_DEPTH];
	logic [63:0]       wpay_q [WINDOW_DEPTH];
	logic [WW-1:0]     whead_q;
	logic [WW:0]       wcnt_q;
	logic [WW:0]       ridx_q;
	logic [SEQ_W-1:0]  nseq_q;
	logic              trun_q;
	logic [TICK_W-1:0] tleft_q;

	out_item_t         out_q;
	logic              ov_q;
	logic              oslot;
	logic              fire;

	logic [BW-1:0]     btail;
	logic [WW-1:0]     wtail, rslot;
	logic              more_send;
	logic [TICK_W-1:0] tstart;
	logic [PSUM_W-1:0] nsum;

	assign oslot     = !ov_q || out_ready;
	assign fire      = ((state_q == ST_SEND) || (state_q == ST_RSND)) && oslot;
	assign out_valid = ov_q;
	assign out_data  = out_q;
	assign q_ready   = (state_q == ST_IDLE);
	assign tstart    = (timeout_ticks == '0) ? TICK_W'(1) : timeout_ticks;
	assign btail     = BW'((BW+1)'(bhead_q) + bcnt_q);
	assign wtail     = WW'((WW+1)'(whead_q) + wcnt_q);
	assign rslot     = WW'((WW+1)'(whead_q) + ridx_q);
	assign nsum      = PSUM_W'(nseq_q) + byte_sum(buf_rd_q, PAYLOAD_BYTES);
	// After this move, can another packet leave?
	assign more_send = (wcnt_q + 1'b1 < (WW+1)'(WINDOW_DEPTH)) && (bcnt_q > (BW+1)'(1));

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_data.op == OP_SEND
			&& bcnt_q < (BW+1)'(BUFFER_DEPTH))
			buf_mem[btail] <= q_data.payload;
		buf_rd_q <= buf_mem[bhead_q];
		if (state_q == ST_SEND && oslot) begin
			wseq_q[wtail] <= nseq_q;
			wsum_q[wtail] <= nsum;
			wpay_q[wtail] <= buf_rd_q;
		end
		if (oslot) begin
			if (state_q == ST_SEND) begin
				out_q.pkt_seq      <= nseq_q;
				out_q.pkt_checksum <= nsum;
				out_q.pkt_payload  <= buf_rd_q;
				out_q.is_resend    <= 1'b0;
				out_q.last         <= !more_send;
			end else begin
				out_q.pkt_seq      <= wseq_q[rslot];
				out_q.pkt_checksum <= wsum_q[rslot];
				out_q.pkt_payload  <= wpay_q[rslot];
				out_q.is_resend    <= 1'b1;
				out_q.last         <= (ridx_q + 1'b1 == wcnt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bhead_q <= '0;
			bcnt_q  <= '0;
			whead_q <= '0;
			wcnt_q  <= '0;
			ridx_q  <= '0;
			nseq_q  <= '0;
			trun_q  <= 1'b0;
			tleft_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (fire)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_data.op)
							OP_SEND: begin
								if (bcnt_q < (BW+1)'(BUFFER_DEPTH))
									bcnt_q <= bcnt_q + 1'b1;
								if (wcnt_q < (WW+1)'(WINDOW_DEPTH)) begin
									trun_q  <= 1'b1;
									tleft_q <= tstart;
									// buffer non-empty after the push is guaranteed
									state_q <= ST_RD;
								end
							end
							OP_ACK: begin
								if (wcnt_q != '0 && SEQ_W'(wseq_q[whead_q]) == q_data.ack_num[SEQ_W-1:0]
									&& q_data.ack_num[ACKF_W-1:SEQ_W] == '0) begin
									whead_q <= (whead_q == WW'(WINDOW_DEPTH-1)) ? '0 : whead_q + 1'b1;
									wcnt_q  <= wcnt_q - 1'b1;
									trun_q  <= (wcnt_q > (WW+1)'(1));
								end else begin
									trun_q  <= (wcnt_q != '0);
								end
								tleft_q <= tstart;
							end
							OP_TICK: begin
								if (trun_q) begin
									if (tleft_q <= TICK_W'(1)) begin
										tleft_q <= tstart;
										ridx_q  <= '0;
										if (wcnt_q != '0)
											state_q <= ST_RSND;
									end else begin
										tleft_q <= tleft_q - 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					// wait for the registered buffer read
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (oslot) begin
						bhead_q <= (bhead_q == BW'(BUFFER_DEPTH-1)) ? '0 : bhead_q + 1'b1;
						bcnt_q  <= bcnt_q - 1'b1;
						wcnt_q  <= wcnt_q + 1'b1;
						nseq_q  <= (nseq_q == SEQ_W'(SEQ_MOD-1)) ? '0 : nseq_q + 1'b1;
						state_q <= more_send ? ST_RD : ST_IDLE;
					end
				end
				ST_RSND: begin
					if (oslot) begin
						ridx_q <= ridx_q + 1'b1;
						if (ridx_q + 1'b1 == wcnt_q)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_wcnt: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= (WW+1)'(WINDOW_DEPTH)) else $error("window overfill");
	a_bcnt: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= (BW+1)'(BUFFER_DEPTH)) else $error("buffer overfill");
	a_send_buf: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND |-> bcnt_q != '0) else $error("send from empty buffer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q && $stable(out_q)) else $error("output lost");
endmodule

// ----- src/go_back_n_sender.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N ARQ sender: send buffer, sliding window and retransmission timer.
// ----------------------------------------------------------------------------
// An input request is classified in the front end (checksum and NACK check on
// acks) and queued for the back end. Acks and ticks are handled in the idle
// state of the back end. A send that opens the window emits each packet by a
// buffer memory read, then a window write and output; a timeout resends the
// window at one packet per cycle while the output is not stalled. Results
// leave through a registered output stage. The window (8 packets) and the
// send buffer (64 payloads) are fixed in the package.
module go_back_n_sender #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gbn_pkg::TICK_W-1:0] cfg_wdata,
	gbn_if.sink                        in_ch,
	gbn_if.source                      out_ch
);
	import gbn_pkg::*;

	logic [TICK_W-1:0] timeout_q;
	logic              q_valid, q_ready;
	req_t              q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_we)
			timeout_q <= cfg_wdata;
	end

	gbn_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES), .QDEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	gbn_back #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .timeout_ticks(timeout_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule
